// File: design/dtt_pkg.sv
// Shared constants, codes and types of the delayed task table.
package dtt_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MAX_OUT     = 8;
  localparam int FIRE_W      = $clog2(MAX_OUT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int MODE_W    = 2;
  localparam int HANDLER_W = 8;
  localparam int DELAY_W   = 16;
  localparam int SIDX_W    = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_SCHEDULE   = 2'd0,
    MODE_UNSCHEDULE = 2'd1,
    MODE_TICK       = 2'd2,
    MODE_COMPLETE   = 2'd3
  } mode_t;

  typedef enum logic [MODE_W-1:0] {
    KIND_SCHEDULE   = 2'd0,
    KIND_UNSCHEDULE = 2'd1,
    KIND_DUE        = 2'd2,
    KIND_COMPLETE   = 2'd3
  } kind_t;

  typedef struct packed {
    mode_t                mode;
    logic [HANDLER_W-1:0] handler_id;
    logic [DELAY_W-1:0]   delay_value;
    logic [DELAY_W-1:0]   tick_count;
    logic [SIDX_W-1:0]    slot_index;
    logic                 idx_in_range;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } back_state_t;

endpackage

// File: design/dtt_if.sv
// Channel interfaces: request transactions in, result transactions out.
interface dtt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  handler_id;
  logic [15:0] delay_value;
  logic [15:0] tick_count;
  logic [2:0]  slot_index;

  modport source (output valid, mode, handler_id, delay_value, tick_count, slot_index,
                  input ready);
  modport sink (input valid, mode, handler_id, delay_value, tick_count, slot_index,
                output ready);
endinterface

interface dtt_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic       ok;
  logic [2:0] slot;
  logic [7:0] due_handler;
  logic       last;

  modport source (output valid, result_kind, ok, slot, due_handler, last, input ready);
  modport sink (input valid, result_kind, ok, slot, due_handler, last, output ready);
endinterface

// File: design/dtt_front.sv
// Front end: accepts request transactions, drops empty ticks, classifies complete index.
module dtt_front (
  dtt_req_if.sink       req,
  input  logic          q_full,
  output logic          push,
  output dtt_pkg::cmd_t cmd
);
  import dtt_pkg::*;

  logic empty_tick;

  assign empty_tick = (mode_t'(req.mode) == MODE_TICK) && (req.tick_count == '0);
  assign req.ready  = !q_full;
  assign push       = req.valid && !q_full && !empty_tick;

  always_comb begin
    cmd.mode         = mode_t'(req.mode);
    cmd.handler_id   = req.handler_id;
    cmd.delay_value  = req.delay_value;
    cmd.tick_count   = req.tick_count;
    cmd.slot_index   = req.slot_index;
    cmd.idx_in_range = (int'(req.slot_index) < NUM_SLOTS);
  end

endmodule

// File: design/dtt_queue.sv
// Short command queue between front and back end.
module dtt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dtt_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output dtt_pkg::cmd_t rdata
);
  import dtt_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push && !full) - QCNT_W'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// File: design/dtt_back.sv
// Back end: slot table, scanner (one slot per cycle unless the output stalls) and result register.
module dtt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  dtt_pkg::cmd_t q_cmd,
  output logic          pop,
  dtt_rsp_if.source     rsp
);
  import dtt_pkg::*;

  logic [DELAY_W-1:0]   slot_delay   [NUM_SLOTS];
  logic [HANDLER_W-1:0] slot_handler [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_running;

  back_state_t          state, state_next;
  cmd_t                 cmd;
  logic [SLOT_W-1:0]    idx;
  logic [FIRE_W-1:0]    fired;
  logic                 pend_v;
  logic [SIDX_W-1:0]    pend_slot;
  logic [HANDLER_W-1:0] pend_handler;

  logic                 out_v;
  kind_t                out_kind;
  logic                 out_ok;
  logic [SIDX_W-1:0]    out_slot;
  logic [HANDLER_W-1:0] out_handler;
  logic                 out_last;

  logic [DELAY_W-1:0]   cur_delay;
  logic [HANDLER_W-1:0] cur_handler;
  logic                 cur_running;
  logic                 cur_live;
  logic                 last_idx;
  logic                 out_free;

  logic                 emit;
  kind_t                e_kind;
  logic                 e_ok;
  logic [SIDX_W-1:0]    e_slot;
  logic [HANDLER_W-1:0] e_handler;
  logic                 e_last;
  logic                 finish;
  logic                 fire;
  logic                 w_delay_en;
  logic [DELAY_W-1:0]   w_delay;
  logic                 w_hand_en;
  logic                 w_run_en;
  logic                 w_run;
  logic                 stall;
  logic                 step;

  assign cur_delay   = slot_delay[idx];
  assign cur_handler = slot_handler[idx];
  assign cur_running = slot_running[idx];
  assign cur_live    = (cur_delay != '0);
  assign last_idx    = (idx == SLOT_W'(NUM_SLOTS - 1));
  assign out_free    = !out_v || rsp.ready;
  assign pop         = (state == ST_IDLE) && !q_empty;

  always_comb begin
    emit       = 1'b0;
    e_kind     = KIND_SCHEDULE;
    e_ok       = 1'b0;
    e_slot     = SIDX_W'(idx);
    e_handler  = cur_handler;
    e_last     = 1'b1;
    finish     = 1'b0;
    fire       = 1'b0;
    w_delay_en = 1'b0;
    w_delay    = cur_delay;
    w_hand_en  = 1'b0;
    w_run_en   = 1'b0;
    w_run      = cur_running;
    if (state == ST_FLUSH) begin
      emit      = 1'b1;
      e_kind    = KIND_DUE;
      e_ok      = 1'b1;
      e_slot    = pend_slot;
      e_handler = pend_handler;
      finish    = 1'b1;
    end else if (state == ST_SCAN) begin
      unique case (cmd.mode)
        MODE_SCHEDULE: begin
          e_kind    = KIND_SCHEDULE;
          e_handler = cmd.handler_id;
          if (!cur_live) begin
            emit       = 1'b1;
            e_ok       = 1'b1;
            finish     = 1'b1;
            w_delay_en = 1'b1;
            w_delay    = cmd.delay_value;
            w_hand_en  = 1'b1;
            w_run_en   = 1'b1;
            w_run      = 1'b0;
          end else if (last_idx) begin
            emit   = 1'b1;
            e_slot = '0;
            finish = 1'b1;
          end
        end
        MODE_UNSCHEDULE: begin
          e_kind    = KIND_UNSCHEDULE;
          e_handler = cmd.handler_id;
          if (cur_live && cur_handler == cmd.handler_id) begin
            emit       = 1'b1;
            e_ok       = 1'b1;
            finish     = 1'b1;
            w_delay_en = 1'b1;
            w_delay    = '0;
            w_run_en   = 1'b1;
            w_run      = 1'b0;
          end else if (last_idx) begin
            emit   = 1'b1;
            e_slot = '0;
            finish = 1'b1;
          end
        end
        MODE_COMPLETE: begin
          e_kind = KIND_COMPLETE;
          emit   = 1'b1;
          finish = 1'b1;
          if (cmd.idx_in_range && cur_running) begin
            e_ok       = 1'b1;
            w_delay_en = 1'b1;
            w_delay    = cmd.delay_value;
            w_run_en   = 1'b1;
            w_run      = 1'b0;
          end else begin
            e_slot    = cmd.slot_index;
            e_handler = '0;
          end
        end
        MODE_TICK: begin
          // previous fired slot goes out now; the newest is held back for its last flag
          e_kind    = KIND_DUE;
          e_ok      = 1'b1;
          e_slot    = pend_slot;
          e_handler = pend_handler;
          e_last    = 1'b0;
          finish    = last_idx;
          if (cur_live && !cur_running) begin
            if (cur_delay <= cmd.tick_count) begin
              if (fired < FIRE_W'(MAX_OUT)) begin
                fire     = 1'b1;
                emit     = pend_v;
                w_run_en = 1'b1;
                w_run    = 1'b1;
              end else begin
                w_delay_en = 1'b1;
                w_delay    = DELAY_W'(1);
              end
            end else begin
              w_delay_en = 1'b1;
              w_delay    = cur_delay - cmd.tick_count;
            end
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
    end
  end

  assign stall = emit && !out_free;
  assign step  = (state != ST_IDLE) && !stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (step && finish) begin
          if (cmd.mode == MODE_TICK && (pend_v || fire)) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (step) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend_v <= 1'b0;
      fired  <= '0;
      out_v  <= 1'b0;
    end else begin
      state <= state_next;
      if (pop) begin
        pend_v <= 1'b0;
        fired  <= '0;
      end else if (step && state == ST_FLUSH) begin
        pend_v <= 1'b0;
      end else if (step && fire) begin
        pend_v <= 1'b1;
        fired  <= fired + 1'b1;
      end
      if (step && emit) begin
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= q_cmd;
      idx <= (q_cmd.mode == MODE_COMPLETE && q_cmd.idx_in_range) ?
             SLOT_W'(q_cmd.slot_index) : '0;
    end else if (step && state == ST_SCAN && !last_idx) begin
      idx <= idx + 1'b1;
    end
    if (step && fire) begin
      pend_slot    <= SIDX_W'(idx);
      pend_handler <= cur_handler;
    end
    if (step && emit) begin
      out_kind    <= e_kind;
      out_ok      <= e_ok;
      out_slot    <= e_slot;
      out_handler <= e_handler;
      out_last    <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_delay[i]   <= '0;
        slot_handler[i] <= '0;
      end
      slot_running <= '0;
    end else if (step && state == ST_SCAN) begin
      if (w_delay_en) begin
        slot_delay[idx] <= w_delay;
      end
      if (w_hand_en) begin
        slot_handler[idx] <= cmd.handler_id;
      end
      if (w_run_en) begin
        slot_running[idx] <= w_run;
      end
    end
  end

  assign rsp.valid       = out_v;
  assign rsp.result_kind = out_kind;
  assign rsp.ok          = out_ok;
  assign rsp.slot        = out_slot;
  assign rsp.due_handler = out_handler;
  assign rsp.last        = out_last;

  a_fired_bound: assert property (@(posedge clk) disable iff (rst)
    fired <= FIRE_W'(MAX_OUT))
    else $error("fired count above limit");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_v)
    else $error("pending due result left in idle");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && out_free) |=> (out_v && out_last && state == ST_IDLE))
    else $error("flush did not deliver last due result");

  a_flush_has_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> pend_v)
    else $error("flush without pending result");

endmodule

// File: design/delayed_task_table_top.sv
// Top level of the delayed task table: front end, command queue, back end.
// A transaction reaches the queue in its accept cycle; the back end then loads it
// from idle and scans one slot per cycle unless the result register stalls it,
// plus a flush state for the last due result of a tick; results leave through a register.
// The back end takes the next queued command only after it returns to idle.
// Reset (synchronous): all slots free, queue and result register empty.
module delayed_task_table_top (
  input  logic      clk,
  input  logic      rst,
  dtt_req_if.sink   req,
  dtt_rsp_if.source rsp
);
  import dtt_pkg::*;

  logic push;
  logic q_full;
  logic q_empty;
  logic pop;
  cmd_t in_cmd;
  cmd_t q_cmd;

  dtt_front u_front (
    .req    (req),
    .q_full (q_full),
    .push   (push),
    .cmd    (in_cmd)
  );

  dtt_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_cmd),
    .full  (q_full),
    .pop   (pop),
    .empty (q_empty),
    .rdata (q_cmd)
  );

  dtt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .rsp     (rsp)
  );

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for delayed_task_table_top: directed and random transactions.
module testbench;
  import dtt_pkg::*;

  typedef struct packed {
    kind_t                kind;
    logic                 ok;
    logic [2:0]           slot;
    logic [HANDLER_W-1:0] handler;
    logic                 last;
  } answer_t;

  logic clk;
  logic rst;
  bit   steady;

  dtt_req_if req();
  dtt_rsp_if rsp();

  delayed_task_table_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Table state as the block should hold it.
  logic [DELAY_W-1:0]   tbl_delay   [NUM_SLOTS] = '{default: '0};
  logic [HANDLER_W-1:0] tbl_handler [NUM_SLOTS] = '{default: '0};
  logic                 tbl_running [NUM_SLOTS] = '{default: 1'b0};

  answer_t pending_answers[$];
  answer_t head;
  int      mismatch_count;
  int      answers_checked;
  int      due_count;
  int      mode_seen[4];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("delayed_task_table_top verification failed");
    $finish;
  end

  function automatic void push_answer(kind_t k, logic ok, int s, logic [HANDLER_W-1:0] h,
                                      logic last = 1'b1);
    answer_t a;
    a.kind    = k;
    a.ok      = ok;
    a.slot    = s[2:0];
    a.handler = h;
    a.last    = last;
    pending_answers.push_back(a);
  endfunction

  function automatic void apply_to_table(mode_t m, logic [HANDLER_W-1:0] h,
                                         logic [DELAY_W-1:0] d, logic [DELAY_W-1:0] t,
                                         logic [SIDX_W-1:0] s);
    bit found;
    int hits[$];
    found = 1'b0;
    case (m)
      MODE_SCHEDULE: begin
        for (int i = 0; i < NUM_SLOTS && !found; i++) begin
          if (tbl_delay[i] == '0) begin
            tbl_delay[i]   = d;
            tbl_handler[i] = h;
            tbl_running[i] = 1'b0;
            push_answer(KIND_SCHEDULE, 1'b1, i, h);
            found = 1'b1;
          end
        end
        if (!found) push_answer(KIND_SCHEDULE, 1'b0, 0, h);
      end
      MODE_UNSCHEDULE: begin
        for (int i = 0; i < NUM_SLOTS && !found; i++) begin
          if (tbl_delay[i] != '0 && tbl_handler[i] == h) begin
            tbl_delay[i]   = '0;
            tbl_running[i] = 1'b0;
            push_answer(KIND_UNSCHEDULE, 1'b1, i, h);
            found = 1'b1;
          end
        end
        if (!found) push_answer(KIND_UNSCHEDULE, 1'b0, 0, h);
      end
      MODE_TICK: begin
        if (t != '0) begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (tbl_delay[i] != '0 && !tbl_running[i]) begin
              if (tbl_delay[i] <= t) begin
                if (hits.size() < MAX_OUT) begin
                  tbl_running[i] = 1'b1;
                  hits.push_back(i);
                end else begin
                  tbl_delay[i] = DELAY_W'(1);
                end
              end else begin
                tbl_delay[i] = tbl_delay[i] - t;
              end
            end
          end
          foreach (hits[k])
            push_answer(KIND_DUE, 1'b1, hits[k], tbl_handler[hits[k]], k == hits.size() - 1);
          due_count += hits.size();
        end
      end
      default: begin
        if (int'(s) < NUM_SLOTS && tbl_running[s]) begin
          tbl_running[s] = 1'b0;
          tbl_delay[s]   = d;
          push_answer(KIND_COMPLETE, 1'b1, int'(s), tbl_handler[s]);
        end else begin
          push_answer(KIND_COMPLETE, 1'b0, int'(s), '0);
        end
      end
    endcase
  endfunction

  // Leaves valid high on return; the next call or the caller lowers it.
  task automatic send_item(input mode_t m, input logic [HANDLER_W-1:0] h,
                           input logic [DELAY_W-1:0] d, input logic [DELAY_W-1:0] t,
                           input logic [SIDX_W-1:0] s);
    while (!steady && $urandom_range(99) < 24) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.mode        <= m;
    req.handler_id  <= h;
    req.delay_value <= d;
    req.tick_count  <= t;
    req.slot_index  <= s;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    apply_to_table(m, h, d, t, s);
    mode_seen[m]++;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at result %0d: %s", answers_checked, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    rsp.ready <= steady || ($urandom_range(99) >= 24);
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d slot %0d",
                                  rsp.result_kind, rsp.slot));
      end else begin
        head = pending_answers.pop_front();
        if (rsp.result_kind !== head.kind)
          report_mismatch($sformatf("result_kind %0d, expected %0d", rsp.result_kind,
                                    head.kind));
        if (rsp.ok !== head.ok)
          report_mismatch($sformatf("ok %0d, expected %0d", rsp.ok, head.ok));
        if (rsp.slot !== head.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", rsp.slot, head.slot));
        if (rsp.due_handler !== head.handler)
          report_mismatch($sformatf("due_handler %0d, expected %0d", rsp.due_handler,
                                    head.handler));
        if (rsp.last !== head.last)
          report_mismatch($sformatf("last %0d, expected %0d", rsp.last, head.last));
      end
      answers_checked++;
    end
  end

  task automatic test_schedule_edges();
    send_item(MODE_SCHEDULE, 8'h00, 16'd0, 16'hFFFF, 3'd7);
    send_item(MODE_SCHEDULE, 8'hFF, 16'hFFFF, 16'h0000, 3'd0);
    send_item(MODE_SCHEDULE, 8'hA5, 16'd1, 16'h5555, 3'd5);
    send_item(MODE_SCHEDULE, 8'h5A, 16'd2, 16'hAAAA, 3'd2);
    send_item(MODE_SCHEDULE, 8'h11, 16'd3, 16'd0, 3'd0);
    send_item(MODE_SCHEDULE, 8'h22, 16'd5, 16'd0, 3'd0);
    send_item(MODE_SCHEDULE, 8'h33, 16'h8000, 16'd0, 3'd0);
    send_item(MODE_SCHEDULE, 8'h44, 16'd100, 16'd0, 3'd0);
    send_item(MODE_SCHEDULE, 8'h55, 16'd7, 16'd0, 3'd0);
    // table full
    send_item(MODE_SCHEDULE, 8'h99, 16'd4, 16'd0, 3'd0);
  endtask

  task automatic test_unschedule_edges();
    send_item(MODE_UNSCHEDULE, 8'hA5, 16'hFFFF, 16'hFFFF, 3'd7);
    // freed slot still holds the handler but must not match
    send_item(MODE_UNSCHEDULE, 8'hA5, 16'd0, 16'd0, 3'd0);
  endtask

  task automatic test_tick_edges();
    send_item(MODE_TICK, 8'hFF, 16'hFFFF, 16'd0, 3'd7);
    send_item(MODE_TICK, 8'h00, 16'd0, 16'd1, 3'd0);
    send_item(MODE_TICK, 8'h00, 16'd0, 16'd4, 3'd0);
    // fired slot can still be unscheduled
    send_item(MODE_UNSCHEDULE, 8'h11, 16'd0, 16'd0, 3'd0);
    send_item(MODE_TICK, 8'h00, 16'd0, 16'hFFFF, 3'd0);
  endtask

  task automatic test_complete_edges();
    send_item(MODE_COMPLETE, 8'hFF, 16'd10, 16'hFFFF, 3'd2);
    send_item(MODE_COMPLETE, 8'h00, 16'd10, 16'd0, 3'd2);
    send_item(MODE_COMPLETE, 8'h00, 16'd0, 16'd0, 3'd4);
    send_item(MODE_COMPLETE, 8'h00, 16'd9, 16'd0, 3'd1);
    send_item(MODE_SCHEDULE, 8'h77, 16'd9, 16'd0, 3'd0);
    send_item(MODE_TICK, 8'h00, 16'd0, 16'hFFFF, 3'd0);
  endtask

  task automatic test_random(input int count);
    mode_t                m;
    logic [HANDLER_W-1:0] h;
    logic [DELAY_W-1:0]   d;
    logic [DELAY_W-1:0]   t;
    logic [SIDX_W-1:0]    s;
    int                   roll;
    int                   busy[$];
    for (int n = 0; n < count; n++) begin
      steady = (n >= count / 3) && (n < count / 3 + 100);
      h = HANDLER_W'($urandom);
      d = DELAY_W'($urandom);
      t = DELAY_W'($urandom);
      s = SIDX_W'($urandom);
      roll = $urandom_range(99);
      m = (roll < 30) ? MODE_SCHEDULE : (roll < 45) ? MODE_UNSCHEDULE :
          (roll < 75) ? MODE_TICK : MODE_COMPLETE;
      roll = $urandom_range(99);
      case (m)
        MODE_SCHEDULE: begin
          if ($urandom_range(99) < 80) h = HANDLER_W'($urandom_range(7));
          if (roll < 70) d = DELAY_W'($urandom_range(40, 1));
          else if (roll < 80) d = '0;
        end
        MODE_UNSCHEDULE: begin
          if (roll < 60) h = tbl_handler[SLOT_W'($urandom_range(NUM_SLOTS - 1))];
          else if (roll < 85) h = HANDLER_W'($urandom_range(7));
        end
        MODE_TICK: begin
          if (roll < 10) t = '0;
          else if (roll < 80) t = DELAY_W'($urandom_range(20, 1));
        end
        default: begin
          busy.delete();
          foreach (tbl_running[i]) if (tbl_running[i]) busy.push_back(i);
          if (busy.size() != 0 && $urandom_range(99) < 85)
            s = SIDX_W'(busy[$urandom_range(busy.size() - 1)]);
          if (roll < 40) d = '0;
          else if (roll < 90) d = DELAY_W'($urandom_range(40, 1));
        end
      endcase
      send_item(m, h, d, t, s);
    end
    steady = 1'b0;
  endtask

  initial begin
    rst             = 1'b1;
    steady          = 1'b0;
    req.valid       = 1'b0;
    req.mode        = MODE_SCHEDULE;
    req.handler_id  = '0;
    req.delay_value = '0;
    req.tick_count  = '0;
    req.slot_index  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_schedule_edges();
    test_unschedule_edges();
    test_tick_edges();
    test_complete_edges();
    test_random(500);

    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4 * NUM_SLOTS) @(posedge clk);

    $display("Sent %0d schedule, %0d unschedule, %0d tick, %0d complete transactions.",
             mode_seen[MODE_SCHEDULE], mode_seen[MODE_UNSCHEDULE], mode_seen[MODE_TICK],
             mode_seen[MODE_COMPLETE]);
    $display("Checked %0d results (%0d due tasks), %0d mismatches.", answers_checked,
             due_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("delayed_task_table_top verification clean");
    end else begin
      $display("delayed_task_table_top verification failed");
    end
    $finish;
  end

endmodule
